/* rtl/mspd_pkg.sv */
// package for the motor speed pd regulator: types, codes and constants
`timescale 1ns / 1ps
package mspd_pkg;

    localparam int WINDOW_LEN_DEF      = 10;
    localparam int TICK_PERIOD_MS_DEF  = 100;
    localparam int COUNTS_PER_TURN_DEF = 207;

    localparam int      CNT_W      = 16;
    localparam int      RPM_W      = 10;
    localparam int      GAIN_W     = 16;
    localparam int      DUTY_W     = 8;
    localparam int      MEAS_W     = 16;
    localparam int      ERR_W      = 18;
    localparam int      CFG_IDX_W  = 2;
    localparam int      CFG_DATA_W = 16;

    localparam int      DIV_NUM_W  = 48;
    localparam int      DIV_DEN_W  = 33;
    localparam int      DIV_CNT_W  = 6;

    localparam longint  GEAR_X10   = 23;
    localparam longint  SPEED_K    = 9600000;
    localparam longint  FACTOR_ONE = 4096000;

    localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd255;
    localparam logic [DUTY_W-1:0] DUTY_MIN = 8'd10;

    localparam logic [GAIN_W-1:0] PROP_RST  = 16'd256;
    localparam logic [GAIN_W-1:0] DERIV_RST = 16'd26;
    localparam logic [RPM_W-1:0]  MAXG_RST  = 10'd400;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN = 2'd0,
        REG_DERIV_GAIN = 2'd1,
        REG_MAX_GOAL = 2'd2
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FF_DIV,
        S_SPD_MUL,
        S_SPD_DIV,
        S_PD_MUL,
        S_PD_SUM,
        S_PD_LOAD,
        S_PD_NUM,
        S_PD_DIV,
        S_FIN
    } t_state;

endpackage

/* rtl/motor_speed_pd_regulator.sv */
// motor speed pd regulator top level with bit-serial divider
`timescale 1ns / 1ps
// One input transaction per control tick gives one result transaction. To form a
// result, a bit-serial restoring divider, one quotient bit per cycle over 48 bits,
// runs two or three times (feed-forward ratio when the goal changes to a new
// nonzero value while a nonzero goal is held, then speed scaling, pd scaling),
// with a state each for the speed multiply, the two pd multiplies, the correction
// factor, the pd numerator and the output. The result sits in an output register,
// so the next tick may be accepted in the cycle the result appears; a result not
// yet taken holds the following tick in its last cycle. Configuration writes are
// taken in any cycle and should be done while the block is idle.
module motor_speed_pd_regulator #(
    parameter int WINDOW_LEN      = mspd_pkg::WINDOW_LEN_DEF,
    parameter int TICK_PERIOD_MS  = mspd_pkg::TICK_PERIOD_MS_DEF,
    parameter int COUNTS_PER_TURN = mspd_pkg::COUNTS_PER_TURN_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [mspd_pkg::CNT_W-1:0]          i_encoder_count,
    input  logic [mspd_pkg::RPM_W-1:0]          i_target_rpm,
    input  logic                                i_forward,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [mspd_pkg::DUTY_W-1:0]         o_pwm_duty,
    output logic                                o_drive_forward,
    output logic [mspd_pkg::MEAS_W-1:0]         o_measured_rpm,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mspd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mspd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int PTR_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int SUM_W = mspd_pkg::CNT_W + $clog2(WINDOW_LEN + 1);
    localparam longint SPD_DEN = 2 * mspd_pkg::GEAR_X10 * COUNTS_PER_TURN * WINDOW_LEN
                                 * TICK_PERIOD_MS;
    localparam int NW = mspd_pkg::DIV_NUM_W;
    localparam int DW = mspd_pkg::DIV_DEN_W;

    mspd_pkg::t_state r_state, n_state;

    logic [mspd_pkg::GAIN_W-1:0] r_prop, r_deriv;
    logic [mspd_pkg::RPM_W-1:0]  r_max_goal;

    logic [mspd_pkg::CNT_W-1:0]  r_ring [WINDOW_LEN];
    logic [PTR_W-1:0]            r_ptr;
    logic [SUM_W-1:0]            r_sum;
    logic [mspd_pkg::CNT_W-1:0]  r_last_cnt;
    logic [mspd_pkg::DUTY_W-1:0] r_duty;
    logic [mspd_pkg::RPM_W-1:0]  r_goal_now;
    logic [mspd_pkg::RPM_W-1:0]  r_goal;
    logic                        r_dir;
    logic signed [mspd_pkg::ERR_W-1:0] r_last_err, r_err;
    logic [mspd_pkg::MEAS_W-1:0] r_meas;
    logic signed [34:0]          r_pa;
    logic signed [35:0]          r_pb;
    logic [33:0]                 r_factor;

    logic [NW-1:0]               r_dv_num, r_dv_q;
    logic [DW-1:0]               r_dv_den, r_dv_rem;
    logic [mspd_pkg::DIV_CNT_W-1:0] r_dv_cnt;

    logic                        r_o_valid;
    logic [mspd_pkg::DUTY_W-1:0] r_o_duty;
    logic                        r_o_dir;
    logic [mspd_pkg::MEAS_W-1:0] r_o_meas;

    // accept-cycle terms
    logic                        in_acc, stop, new_goal, ff_div, take;
    logic [mspd_pkg::DUTY_W-1:0] duty_s, half;
    logic [mspd_pkg::RPM_W-1:0]  gnow_s, goal;
    logic [PTR_W-1:0]            ptr_nx;
    logic [mspd_pkg::CNT_W-1:0]  delta;

    // divider step
    logic [DW:0]                 rem_sh;
    logic                        ge, dv_done;
    logic [NW-1:0]               q_nx;

    // pd terms
    logic [mspd_pkg::MEAS_W-1:0]       meas;
    logic signed [mspd_pkg::ERR_W-1:0] err;
    logic signed [mspd_pkg::ERR_W:0]   diff;
    logic signed [36:0]                fix;
    logic signed [37:0]                fac;
    logic [mspd_pkg::DUTY_W-1:0]       pd_duty;
    logic                              out_free;

    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_o_valid || i_out_ready;

    always_comb begin
        stop     = (r_goal_now != '0) && ((i_forward != r_dir) || (i_target_rpm == '0));
        duty_s   = stop ? '0 : r_duty;
        gnow_s   = stop ? '0 : r_goal_now;
        goal     = (i_target_rpm > r_max_goal) ? r_max_goal : i_target_rpm;
        new_goal = (goal != '0) && (goal != gnow_s);
        ff_div   = new_goal && (gnow_s != '0);
        half     = goal[9] ? mspd_pkg::DUTY_MAX : goal[8:1];
        ptr_nx   = (r_ptr == PTR_W'(WINDOW_LEN - 1)) ? '0 : r_ptr + 1'b1;
        take     = i_encoder_count >= r_last_cnt;
        delta    = i_encoder_count - r_last_cnt;
    end

    always_comb begin
        rem_sh  = {r_dv_rem, r_dv_num[NW-1]};
        ge      = rem_sh >= {1'b0, r_dv_den};
        q_nx    = {r_dv_q[NW-2:0], ge};
        dv_done = (r_dv_cnt == '0);
    end

    always_comb begin
        meas    = (|r_dv_q[NW-1:mspd_pkg::MEAS_W]) ? '1 : r_dv_q[mspd_pkg::MEAS_W-1:0];
        err     = $signed({2'b00, meas}) - $signed({4'b0000, r_goal, 4'b0000});
        diff    = $signed({r_err[mspd_pkg::ERR_W-1], r_err})
                  - $signed({r_last_err[mspd_pkg::ERR_W-1], r_last_err});
        fix     = 37'(r_pa) + 37'(r_pb);
        fac     = 38'(mspd_pkg::FACTOR_ONE) - 38'(fix);
        if (|r_dv_q[NW-1:mspd_pkg::DUTY_W]) begin
            pd_duty = mspd_pkg::DUTY_MAX;
        end else if (r_dv_q[mspd_pkg::DUTY_W-1:0] < mspd_pkg::DUTY_MIN) begin
            pd_duty = mspd_pkg::DUTY_MIN;
        end else begin
            pd_duty = r_dv_q[mspd_pkg::DUTY_W-1:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mspd_pkg::S_IDLE:    if (i_in_valid) begin
                n_state = ff_div ? mspd_pkg::S_FF_DIV : mspd_pkg::S_SPD_MUL;
            end
            mspd_pkg::S_FF_DIV:  if (dv_done) n_state = mspd_pkg::S_SPD_MUL;
            mspd_pkg::S_SPD_MUL: n_state = mspd_pkg::S_SPD_DIV;
            mspd_pkg::S_SPD_DIV: if (dv_done) n_state = mspd_pkg::S_PD_MUL;
            mspd_pkg::S_PD_MUL:  n_state = mspd_pkg::S_PD_SUM;
            mspd_pkg::S_PD_SUM:  n_state = mspd_pkg::S_PD_LOAD;
            mspd_pkg::S_PD_LOAD: n_state = mspd_pkg::S_PD_NUM;
            mspd_pkg::S_PD_NUM:  n_state = mspd_pkg::S_PD_DIV;
            mspd_pkg::S_PD_DIV:  if (dv_done) n_state = mspd_pkg::S_FIN;
            mspd_pkg::S_FIN:     if (out_free) n_state = mspd_pkg::S_IDLE;
            default:             n_state = mspd_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready      = (r_state == mspd_pkg::S_IDLE);
        o_out_valid     = r_o_valid;
        o_pwm_duty      = r_o_duty;
        o_drive_forward = r_o_dir;
        o_measured_rpm  = r_o_meas;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mspd_pkg::S_IDLE;
            r_prop     <= mspd_pkg::PROP_RST;
            r_deriv    <= mspd_pkg::DERIV_RST;
            r_max_goal <= mspd_pkg::MAXG_RST;
            for (int k = 0; k < WINDOW_LEN; k++) r_ring[k] <= '0;
            r_ptr      <= '0;
            r_sum      <= '0;
            r_last_cnt <= '0;
            r_duty     <= '0;
            r_goal_now <= '0;
            r_dir      <= 1'b1;
            r_last_err <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    mspd_pkg::REG_PROP_GAIN:  r_prop     <= i_cfg_data;
                    mspd_pkg::REG_DERIV_GAIN: r_deriv    <= i_cfg_data;
                    mspd_pkg::REG_MAX_GOAL:   r_max_goal <= i_cfg_data[mspd_pkg::RPM_W-1:0];
                    default: ;
                endcase
            end
            if (r_o_valid && i_out_ready && r_state != mspd_pkg::S_FIN) r_o_valid <= 1'b0;

            case (r_state)
                mspd_pkg::S_IDLE: if (in_acc) begin
                    r_dir   <= i_forward;
                    r_goal  <= goal;
                    r_duty  <= (new_goal && !ff_div) ? half : duty_s;
                    r_goal_now <= new_goal ? goal : gnow_s;
                    r_dv_num <= NW'(18'(duty_s) * 18'(goal));
                    r_dv_den <= DW'(gnow_s);
                    r_dv_rem <= '0;
                    r_dv_q   <= '0;
                    r_dv_cnt <= mspd_pkg::DIV_CNT_W'(NW - 1);
                    r_ptr      <= ptr_nx;
                    r_last_cnt <= i_encoder_count;
                    if (take) begin
                        r_sum          <= r_sum - SUM_W'(r_ring[ptr_nx]) + SUM_W'(delta);
                        r_ring[ptr_nx] <= delta;
                    end
                end
                mspd_pkg::S_FF_DIV, mspd_pkg::S_SPD_DIV, mspd_pkg::S_PD_DIV: begin
                    r_dv_rem <= ge ? DW'(rem_sh - {1'b0, r_dv_den}) : DW'(rem_sh);
                    r_dv_num <= {r_dv_num[NW-2:0], 1'b0};
                    r_dv_q   <= q_nx;
                    r_dv_cnt <= r_dv_cnt - 1'b1;
                    if (r_state == mspd_pkg::S_FF_DIV && dv_done) begin
                        r_duty <= (|q_nx[NW-1:mspd_pkg::DUTY_W]) ? mspd_pkg::DUTY_MAX
                                                                 : q_nx[mspd_pkg::DUTY_W-1:0];
                    end
                end
                mspd_pkg::S_SPD_MUL: begin
                    r_dv_num <= NW'(r_sum) * NW'(mspd_pkg::SPEED_K);
                    r_dv_den <= DW'(SPD_DEN);
                    r_dv_rem <= '0;
                    r_dv_q   <= '0;
                    r_dv_cnt <= mspd_pkg::DIV_CNT_W'(NW - 1);
                end
                mspd_pkg::S_PD_MUL: begin
                    r_meas <= meas;
                    r_err  <= err;
                    r_pa   <= $signed({1'b0, r_prop}) * err;
                end
                mspd_pkg::S_PD_SUM: begin
                    r_pb <= $signed({1'b0, r_deriv}) * diff;
                end
                mspd_pkg::S_PD_LOAD: begin
                    r_factor <= fac[37] ? '0 : fac[33:0];
                end
                mspd_pkg::S_PD_NUM: begin
                    r_dv_num <= NW'(42'(r_duty) * 42'(r_factor));
                    r_dv_den <= DW'(mspd_pkg::FACTOR_ONE);
                    r_dv_rem <= '0;
                    r_dv_q   <= '0;
                    r_dv_cnt <= mspd_pkg::DIV_CNT_W'(NW - 1);
                end
                mspd_pkg::S_FIN: if (out_free) begin
                    r_duty     <= pd_duty;
                    r_last_err <= r_err;
                    r_o_valid  <= 1'b1;
                    r_o_duty   <= pd_duty;
                    r_o_dir    <= r_dir;
                    r_o_meas   <= r_meas;
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mspd_pkg::S_SPD_DIV || r_state == mspd_pkg::S_PD_DIV)
        |-> (r_dv_rem < r_dv_den || r_dv_den == '0))
        else $error("divider remainder not below divisor");
    a_duty_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pwm_duty >= mspd_pkg::DUTY_MIN))
        else $error("duty below floor");
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state != mspd_pkg::S_IDLE))
        else $error("transaction accepted without starting work");
    a_ff_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mspd_pkg::S_FF_DIV) |-> (r_dv_den != '0))
        else $error("feed-forward divide by zero goal");
`endif

endmodule
